// ===== rtl/core/pbp_pkg.sv =====
package pbp_pkg;

	// Input kinds, carried on s_axis_tuser
	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UNCOND = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SQUASH = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 7;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_MODULUS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LIMIT  = 1'b1;
	localparam logic [CFG_W-1:0] RESET_MODULUS = 7'd61;
	localparam logic [CFG_W-1:0] RESET_LIMIT   = 7'd127;

	// Field and bus widths
	localparam int ADDR_W      = 32;
	localparam int MOD_W       = 7;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_SUM_W   = 13;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_SUM_W - 1;

	// Remainder unit: address bits retired per cycle
	localparam int DIGIT_W   = 8;
	localparam int DIV_STEPS = ADDR_W / DIGIT_W;

	// Weights summed per cycle in a lookup
	localparam int SUM_LANES = 8;

endpackage

// ===== rtl/core/pbp_row_sel.sv =====
// Iterative address-to-row mapping: address mod modulus, then mod TABLE_ENTRIES.
module pbp_row_sel import pbp_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ADDR_W-1:0]                address,
	input  logic [MOD_W-1:0]                 modulus,
	output logic                             done,
	output logic [$clog2(TABLE_ENTRIES)-1:0] row
);

	localparam int ROW_W  = $clog2(TABLE_ENTRIES);
	localparam int WRAP_W = ROW_W + 2;
	localparam int STEP_W = (DIV_STEPS > 2) ? $clog2(DIV_STEPS) : 1;

	logic [ADDR_W-1:0] addr_q;
	logic [MOD_W-1:0]  mod_q;
	logic [MOD_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              wrap_q;
	logic              done_q;
	logic [ROW_W-1:0]  row_q;

	logic [MOD_W-1:0]  rem_next;
	logic [ROW_W-1:0]  row_next;

	// One remainder digit per cycle: eight restoring steps on narrow values
	always_comb begin
		logic [MOD_W:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < DIGIT_W; i++) begin
			r = {r[MOD_W-1:0], addr_q[ADDR_W-1-i]};
			if (r >= {1'b0, mod_q}) begin
				r = r - {1'b0, mod_q};
			end
		end
		rem_next = r[MOD_W-1:0];
	end

	// Fold the remainder into the table: restoring reduction by a constant
	always_comb begin
		logic [WRAP_W-1:0] rr;
		rr = '0;
		for (int i = MOD_W - 1; i >= 0; i--) begin
			rr = {rr[WRAP_W-2:0], rem_q[i]};
			if (rr >= WRAP_W'(TABLE_ENTRIES)) begin
				rr = rr - WRAP_W'(TABLE_ENTRIES);
			end
		end
		if (mod_q == '0) begin
			row_next = '0;
		end else begin
			row_next = rr[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			wrap_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					wrap_q <= 1'b1;
				end
			end else if (wrap_q) begin
				wrap_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= address;
			mod_q  <= modulus;
			rem_q  <= '0;
		end else if (busy_q) begin
			addr_q <= addr_q << DIGIT_W;
			rem_q  <= rem_next;
		end
		if (wrap_q) begin
			row_q <= row_next;
		end
	end

	assign done = done_q;
	assign row  = row_q;

endmodule

// ===== rtl/core/perceptron_branch_predictor.sv =====
// Channel   Dir  Payload (tdata / tuser, low bit first)              Transfer
// s_axis    in   tdata: branch_address[31:0], taken[32], zero pad    tvalid & tready
//                tuser: kind[1:0]
// m_axis    out  tdata: predicted_taken[0], perceptron_sum[13:1],    tvalid & tready
//                zero pad
// cfg       in   cfg_index 0 index_modulus, 1 weight_limit           cfg_we
//
// One item at a time. A lookup or an update passes through the serial remainder unit
// (8 address bits a cycle) and the single-port row memory (read, then write back); a
// lookup then sums its weights in chunks of 8. An unconditional branch or squash
// goes straight to the result. After reset a clearing pass zeroes the row memory
// with s_axis_tready low; configuration writes are taken throughout.
// A stalled result waits in the output register while the next item runs; an
// item finishing behind it holds until that register frees.
module perceptron_branch_predictor import pbp_pkg::*; #(
	parameter int TABLE_ENTRIES  = 64,
	parameter int HISTORY_LENGTH = 16,
	parameter int WEIGHT_BITS    = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// slave stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // branch_address[31:0], taken[32]
	input  logic [KIND_W-1:0]      s_axis_tuser,  // kind[1:0]
	// master stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // predicted_taken[0], perceptron_sum[13:1]
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int ROW_W    = $clog2(TABLE_ENTRIES);
	localparam int ROW_BITS = (HISTORY_LENGTH + 1) * WEIGHT_BITS;
	localparam int NCH      = (HISTORY_LENGTH + SUM_LANES - 1) / SUM_LANES;
	localparam int PADH     = NCH * SUM_LANES;
	localparam int PADW     = PADH * WEIGHT_BITS;
	localparam int WX       = WEIGHT_BITS + 1;
	localparam int CAP_V    = (1 << (WEIGHT_BITS - 1)) - 1;
	localparam int CNT_W    = $clog2(NCH + 1);
	localparam int SUM_NEED = WEIGHT_BITS + $clog2(HISTORY_LENGTH + 2);
	localparam int ACC_W    = (SUM_NEED > OUT_SUM_W) ? SUM_NEED : OUT_SUM_W;
	localparam logic signed [WX-1:0] ONE_X = WX'(1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ROW   = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_DATA  = 3'd4;
	localparam logic [2:0] ST_SUM   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	// Row memory: bias in the low slice, weight n in slice n+1
	logic [ROW_BITS-1:0] mem [TABLE_ENTRIES];
	logic [ROW_BITS-1:0] rd_q;
	logic                mem_we;
	logic [ROW_W-1:0]    mem_addr;
	logic [ROW_BITS-1:0] mem_wd;

	logic [2:0]                 state_q;
	logic [ROW_W-1:0]           clr_q;
	logic [HISTORY_LENGTH-1:0]  hist_q;
	logic [MOD_W-1:0]           modulus_q;
	logic [CFG_W-1:0]           limit_q;
	logic [CNT_W-1:0]           sum_cnt_q;
	logic                       out_valid_q;
	logic [OUT_TDATA_W-1:0]     out_data_q;

	logic [KIND_W-1:0]          kind_q;
	logic                       taken_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [PADW-1:0]            wsh_q;
	logic [PADH-1:0]            hsh_q;

	logic                       s_xfer;
	logic                       row_start;
	logic                       row_done;
	logic [ROW_W-1:0]           row;
	logic                       out_load;
	logic signed [WX-1:0]       lim;
	logic [ROW_BITS-1:0]        wr_row;
	logic signed [ACC_W-1:0]    part;
	logic [KIND_W-1:0]          in_kind;

	function automatic logic [WEIGHT_BITS-1:0] train(
		input logic [WEIGHT_BITS-1:0] v,
		input logic                   up,
		input logic signed [WX-1:0]   bound
	);
		logic signed [WX-1:0] t;
		t = WX'(signed'(v));
		t = up ? t + ONE_X : t - ONE_X;
		if (t > bound) begin
			t = bound;
		end
		if (t < -bound) begin
			t = -bound;
		end
		return t[WEIGHT_BITS-1:0];
	endfunction

	assign in_kind       = s_axis_tuser;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_xfer        = s_axis_tvalid && s_axis_tready;
	assign row_start     = s_xfer && (in_kind == KIND_LOOKUP || in_kind == KIND_UPDATE);
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	pbp_row_sel #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_row_sel (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (row_start),
		.address (s_axis_tdata[ADDR_W-1:0]),
		.modulus (modulus_q),
		.done    (row_done),
		.row     (row)
	);

	// Effective saturation bound: the configured limit, capped by the weight width
	always_comb begin
		if (32'(limit_q) > 32'(CAP_V)) begin
			lim = WX'(CAP_V);
		end else begin
			lim = WX'(limit_q);
		end
	end

	// Trained row: bias toward the outcome, each weight toward agreement
	always_comb begin
		wr_row[WEIGHT_BITS-1:0] = train(rd_q[WEIGHT_BITS-1:0], taken_q, lim);
		for (int n = 0; n < HISTORY_LENGTH; n++) begin
			wr_row[(n+1)*WEIGHT_BITS +: WEIGHT_BITS] =
				train(rd_q[(n+1)*WEIGHT_BITS +: WEIGHT_BITS], hist_q[n] == taken_q, lim);
		end
	end

	// One chunk of the dot product: add on a taken history bit, subtract otherwise
	always_comb begin
		logic signed [ACC_W-1:0] term;
		part = '0;
		for (int j = 0; j < SUM_LANES; j++) begin
			term = ACC_W'(signed'(wsh_q[j*WEIGHT_BITS +: WEIGHT_BITS]));
			part = hsh_q[j] ? part + term : part - term;
		end
	end

	// Single port: the clearing pass and write-back share the address with the read
	always_comb begin
		mem_we   = (state_q == ST_CLEAR) || (state_q == ST_DATA && kind_q == KIND_UPDATE);
		mem_addr = (state_q == ST_CLEAR) ? clr_q : row;
		mem_wd   = (state_q == ST_CLEAR) ? '0 : wr_row;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end else begin
			rd_q <= mem[mem_addr];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= RESET_MODULUS;
			limit_q   <= RESET_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INDEX_MODULUS: modulus_q <= cfg_data;
				REG_WEIGHT_LIMIT:  limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, history and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			hist_q      <= '0;
			sum_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a finished result, or drop the one just taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (clr_q == ROW_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_xfer) begin
						case (in_kind) inside
							KIND_LOOKUP, KIND_UPDATE: state_q <= ST_ROW;
							KIND_UNCOND: begin
								hist_q  <= (hist_q << 1) | HISTORY_LENGTH'(1);
								state_q <= ST_DONE;
							end
							default: begin
								hist_q  <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ROW: begin
					if (row_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_DATA;
				ST_DATA: begin
					sum_cnt_q <= '0;
					if (kind_q == KIND_UPDATE) begin
						hist_q  <= (hist_q << 1) | HISTORY_LENGTH'(taken_q);
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					sum_cnt_q <= sum_cnt_q + CNT_W'(1);
					if (sum_cnt_q == CNT_W'(NCH - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			kind_q  <= in_kind;
			taken_q <= s_axis_tdata[ADDR_W];
		end
		if (state_q == ST_DATA) begin
			acc_q <= ACC_W'(signed'(rd_q[WEIGHT_BITS-1:0]));
			wsh_q <= PADW'(rd_q[ROW_BITS-1:WEIGHT_BITS]);
			hsh_q <= PADH'(hist_q);
		end else if (state_q == ST_SUM) begin
			acc_q <= acc_q + part;
			wsh_q <= wsh_q >> (SUM_LANES * WEIGHT_BITS);
			hsh_q <= hsh_q >> SUM_LANES;
		end
		if (out_load) begin
			if (kind_q == KIND_LOOKUP) begin
				out_data_q <= {{OUT_PAD_W{1'b0}}, acc_q[OUT_SUM_W-1:0], ~acc_q[ACC_W-1]};
			end else begin
				out_data_q <= '0;
			end
		end
	end

endmodule

// ===== rtl/core/pbp_checker.sv =====
module pbp_checker import pbp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic       s_xfer;
	logic       m_xfer;
	logic [1:0] pend_q;

	assign s_xfer = s_axis_tvalid && s_axis_tready;
	assign m_xfer = m_axis_tvalid && m_axis_tready;

	// Items accepted and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (s_xfer && !m_xfer) begin
			pend_q <= pend_q + 2'd1;
		end else if (m_xfer && !s_xfer) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// One item in flight: the input closes after each transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> !s_axis_tready)
		else $error("input accepted on consecutive cycles");

	// No result without an item behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer |-> (pend_q != 2'd0))
		else $error("result with no pending item");

	// At most one waiting result plus one in progress
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many items outstanding");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind perceptron_branch_predictor pbp_checker u_pbp_checker (.*);
